// ----- design/ssosc_pkg.sv -----
// shared types, constants and helpers for the servo sine oscillator
package ssosc_pkg;

    localparam int PHASE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    localparam int PERIOD_W    = 16;
    localparam int OFFSET_W    = 12;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int ANGLE_W     = 8;
    localparam int SUM_W       = 11;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;
    localparam logic [ANGLE_W-1:0]  ANGLE_RESET  = 8'd90;

    localparam logic signed [SUM_W-1:0] ANGLE_MID = 11'sd90;
    localparam logic signed [SUM_W-1:0] ANGLE_MAX = 11'sd180;

    // quarter-wave polynomial coefficients, Q16
    localparam logic [16:0] SIN_K1 = 17'd102944;
    localparam logic [16:0] SIN_K3 = 17'd42334;
    localparam logic [16:0] SIN_K5 = 17'd5223;
    localparam logic [16:0] SIN_K7 = 17'd307;
    localparam logic [16:0] SIN_SAT = 17'd32767;

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_REFRESH = 3'd1,
        CMD_START   = 3'd2,
        CMD_SET     = 3'd3,
        CMD_STOP    = 3'd4
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD_MS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIM          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REVERSE       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ATTACHED      = 3'd6;

    function automatic logic [ANGLE_W-1:0] clamp180(input logic signed [SUM_W-1:0] v);
        logic [ANGLE_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ANGLE_MAX) begin
            r = ANGLE_MAX[ANGLE_W-1:0];
        end else begin
            r = v[ANGLE_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/ssosc_div.sv -----
// bit-serial long division giving the cycle phase fraction of elapsed over period
module ssosc_div
    import ssosc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [TIME_BITS-1:0]  elapsed,
    input  logic [PERIOD_W-1:0]   period,
    output logic                  done,
    output logic [PHASE_BITS-1:0] frac
);

    localparam int STEPS = TIME_BITS + PHASE_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [TIME_BITS-1:0]  dvd_reg;
    logic [PERIOD_W-1:0]   rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;

    logic [PERIOD_W:0]   rem_sh;
    logic [PERIOD_W:0]   rem_diff;
    logic                ge;
    logic [PERIOD_W-1:0] rem_next;

    // dividend is elapsed followed by PHASE_BITS zeros; only the low quotient bits are kept,
    // which equals ((elapsed mod period) << PHASE_BITS) / period
    assign rem_sh   = {rem_reg, dvd_reg[TIME_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, period};
    assign ge       = rem_sh >= {1'b0, period};
    assign rem_next = ge ? rem_diff[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= elapsed;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[TIME_BITS-2:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[PHASE_BITS-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    // a zero period gives phase zero
    assign frac = (period == '0) ? '0 : quo_reg;

endmodule

// ----- design/ssosc_sine.sv -----
// sine polynomial and amplitude scaling on one shared multiplier
module ssosc_sine
    import ssosc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [PHASE_BITS-1:0] phase,
    input  logic signed [7:0]     amplitude,
    output logic                  done,
    output logic signed [7:0]     term
);

    localparam int ZQ_W = PHASE_BITS - 1;
    localparam logic [ZQ_W-1:0] QSIZE = {1'b1, {(PHASE_BITS-2){1'b0}}};

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_SQUARE,
        SEQ_POLY7,
        SEQ_POLY5,
        SEQ_POLY3,
        SEQ_POLY1,
        SEQ_SCALE
    } seq_t;

    seq_t              seq_reg;
    logic              mul_done_reg;
    logic              done_reg;
    logic [16:0]       z_reg;
    logic [16:0]       z2_reg;
    logic [16:0]       t_reg;
    logic [14:0]       s_reg;
    logic [7:0]        amag_reg;
    logic              neg_reg;
    logic [33:0]       prod_reg;
    logic signed [7:0] term_reg;

    logic [1:0]      quad;
    logic [ZQ_W-1:0] zq;
    logic [16:0]     z_start;
    logic [16:0]     op_a;
    logic [16:0]     op_b;
    logic [17:0]     prod_hi;
    logic [16:0]     s_full;
    logic [7:0]      mag;

    assign quad    = phase[PHASE_BITS-1 -: 2];
    assign zq      = quad[0] ? (QSIZE - {1'b0, phase[PHASE_BITS-3:0]})
                             : {1'b0, phase[PHASE_BITS-3:0]};
    assign z_start = {zq, {(18-PHASE_BITS){1'b0}}};
    assign prod_hi = prod_reg[33:16];
    assign s_full  = prod_hi[17:1];
    assign mag     = {1'b0, prod_reg[21:15]};

    always_comb begin
        case (seq_reg)
            SEQ_SQUARE: begin
                op_a = z_reg;
                op_b = z_reg;
            end
            SEQ_POLY7: begin
                op_a = SIN_K7;
                op_b = z2_reg;
            end
            SEQ_POLY5, SEQ_POLY3: begin
                op_a = t_reg;
                op_b = z2_reg;
            end
            SEQ_POLY1: begin
                op_a = z_reg;
                op_b = t_reg;
            end
            SEQ_SCALE: begin
                op_a = {9'd0, amag_reg};
                op_b = {2'd0, s_reg};
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // each step: multiply into prod_reg, then use selected bits of the registered product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg      <= SEQ_IDLE;
            mul_done_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (seq_reg)
                SEQ_IDLE: begin
                    if (start) begin
                        z_reg        <= z_start;
                        amag_reg     <= amplitude[7] ? (~amplitude + 8'd1) : amplitude;
                        neg_reg      <= amplitude[7] ^ quad[1];
                        mul_done_reg <= 1'b0;
                        seq_reg      <= SEQ_SQUARE;
                    end
                end
                default: begin
                    if (!mul_done_reg) begin
                        prod_reg     <= op_a * op_b;
                        mul_done_reg <= 1'b1;
                    end else begin
                        mul_done_reg <= 1'b0;
                        case (seq_reg)
                            SEQ_SQUARE: begin
                                z2_reg  <= prod_hi[16:0];
                                seq_reg <= SEQ_POLY7;
                            end
                            SEQ_POLY7: begin
                                t_reg   <= SIN_K5 - prod_hi[16:0];
                                seq_reg <= SEQ_POLY5;
                            end
                            SEQ_POLY5: begin
                                t_reg   <= SIN_K3 - prod_hi[16:0];
                                seq_reg <= SEQ_POLY3;
                            end
                            SEQ_POLY3: begin
                                t_reg   <= SIN_K1 - prod_hi[16:0];
                                seq_reg <= SEQ_POLY1;
                            end
                            SEQ_POLY1: begin
                                s_reg   <= (s_full > SIN_SAT) ? SIN_SAT[14:0] : s_full[14:0];
                                seq_reg <= SEQ_SCALE;
                            end
                            SEQ_SCALE: begin
                                // magnitude truncation equals truncation toward zero
                                term_reg <= neg_reg ? -mag : mag;
                                done_reg <= 1'b1;
                                seq_reg  <= SEQ_IDLE;
                            end
                            default: begin
                                seq_reg <= SEQ_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign term = term_reg;

endmodule

// ----- design/servo_sine_oscillator_core.sv -----
// servo sine oscillator: command sequencer, configuration registers and output register
//
// Input channel s_*: one command per transaction (tick, refresh, start, set position,
// stop) with set_value used by set position. Output channel m_*: exactly one result
// transaction per command, carrying the servo angle after the command and a strobe
// that is high when the command drove the servo.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at the clock edge;
// the user must write only while no command is in progress; the block does not enforce it.
// Tick, start, set position, stop and an inactive refresh give their result in
// the register in the cycle after acceptance. A refresh that drives the servo runs a
// bit-serial divider of TIME_BITS + PHASE_BITS steps and then six passes of the shared
// multiplier. s_ready is low from acceptance until its result is registered.
// The output register frees the input side: a new command is taken in the cycle the
// pending result is taken. While m_ready is low with a result waiting, s_ready is low.
// Reset (aresetn low, synchronous): registers to their defaults, angle 90, not
// oscillating, elapsed time zero, no result pending.
module servo_sine_oscillator_core
    import ssosc_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_command,
    input  logic signed [8:0]      s_set_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [ANGLE_W-1:0]     m_position,
    output logic                   m_drive_strobe
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SINE,
        ST_POST
    } state_t;

    logic signed [7:0]     amplitude_reg;
    logic signed [7:0]     center_offset_reg;
    logic [PERIOD_W-1:0]   period_ms_reg;
    logic [OFFSET_W-1:0]   phase_offset_reg;
    logic signed [6:0]     trim_reg;
    logic                  reverse_reg;
    logic                  attached_reg;

    state_t                state_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic                  oscillating_reg;
    logic [ANGLE_W-1:0]    angle_now_reg;
    logic                  m_valid_reg;
    logic [ANGLE_W-1:0]    m_position_reg;
    logic                  m_drive_strobe_reg;

    logic                   s_accept;
    cmd_t                   cmd;
    logic                   refresh_go;
    logic                   div_done;
    logic [PHASE_BITS-1:0]  div_frac;
    logic [PHASE_BITS-1:0]  phase_off;
    logic [PHASE_BITS-1:0]  phase;
    logic                   sine_start;
    logic                   sine_done;
    logic signed [7:0]      sine_term;
    logic signed [SUM_W-1:0] trim_ext;
    logic signed [SUM_W-1:0] sp_sum;
    logic signed [SUM_W-1:0] sp_mirror;
    logic [ANGLE_W-1:0]     sp_angle;
    logic signed [SUM_W-1:0] osc_sum;
    logic [ANGLE_W-1:0]     osc_clamped;
    logic [ANGLE_W-1:0]     osc_mirror;
    logic signed [SUM_W-1:0] osc_trimmed;
    logic [ANGLE_W-1:0]     osc_angle;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amplitude_reg     <= '0;
            center_offset_reg <= '0;
            period_ms_reg     <= PERIOD_RESET;
            phase_offset_reg  <= '0;
            trim_reg          <= '0;
            reverse_reg       <= 1'b0;
            attached_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_AMPLITUDE:     amplitude_reg     <= cfg_wdata[7:0];
                REG_CENTER_OFFSET: center_offset_reg <= cfg_wdata[7:0];
                REG_PERIOD_MS:     period_ms_reg     <= cfg_wdata[PERIOD_W-1:0];
                REG_PHASE_OFFSET:  phase_offset_reg  <= cfg_wdata[OFFSET_W-1:0];
                REG_TRIM:          trim_reg          <= cfg_wdata[6:0];
                REG_REVERSE:       reverse_reg       <= cfg_wdata[0];
                REG_ATTACHED:      attached_reg      <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept   = s_valid && s_ready;
    assign cmd        = cmd_t'(s_command);
    assign refresh_go = s_accept && (cmd == CMD_REFRESH) && attached_reg && oscillating_reg;
    assign sine_start = (state_reg == ST_DIV) && div_done;

    // phase offset is given in 1/4096 turn; rescale to PHASE_BITS
    generate
        if (PHASE_BITS >= OFFSET_W) begin : g_off_up
            assign phase_off = PHASE_BITS'(phase_offset_reg) << (PHASE_BITS - OFFSET_W);
        end else begin : g_off_down
            assign phase_off = phase_offset_reg[OFFSET_W-1 -: PHASE_BITS];
        end
    endgenerate

    assign phase = div_frac + phase_off;

    ssosc_div #(
        .PHASE_BITS (PHASE_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (refresh_go),
        .elapsed (elapsed_reg),
        .period  (period_ms_reg),
        .done    (div_done),
        .frac    (div_frac)
    );

    ssosc_sine #(
        .PHASE_BITS (PHASE_BITS)
    ) u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (sine_start),
        .phase     (phase),
        .amplitude (amplitude_reg),
        .done      (sine_done),
        .term      (sine_term)
    );

    // set position: trim, then mirror, then clamp
    assign trim_ext  = {{(SUM_W-7){trim_reg[6]}}, trim_reg};
    assign sp_sum    = {{(SUM_W-9){s_set_value[8]}}, s_set_value} + trim_ext;
    assign sp_mirror = reverse_reg ? (ANGLE_MAX - sp_sum) : sp_sum;
    assign sp_angle  = clamp180(sp_mirror);

    // oscillation: centre, clamp, mirror, trim, clamp again
    assign osc_sum     = {{(SUM_W-8){sine_term[7]}}, sine_term}
                       + {{(SUM_W-8){center_offset_reg[7]}}, center_offset_reg} + ANGLE_MID;
    assign osc_clamped = clamp180(osc_sum);
    assign osc_mirror  = reverse_reg ? (ANGLE_MAX[ANGLE_W-1:0] - osc_clamped) : osc_clamped;
    assign osc_trimmed = {{(SUM_W-ANGLE_W){1'b0}}, osc_mirror} + trim_ext;
    assign osc_angle   = clamp180(osc_trimmed);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            elapsed_reg        <= '0;
            oscillating_reg    <= 1'b0;
            angle_now_reg      <= ANGLE_RESET;
            m_valid_reg        <= 1'b0;
            m_position_reg     <= ANGLE_RESET;
            m_drive_strobe_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        m_valid_reg        <= 1'b1;
                        m_position_reg     <= angle_now_reg;
                        m_drive_strobe_reg <= 1'b0;
                        case (cmd)
                            CMD_TICK: begin
                                elapsed_reg <= elapsed_reg + TIME_BITS'(1);
                            end
                            CMD_REFRESH: begin
                                if (refresh_go) begin
                                    m_valid_reg <= 1'b0;
                                    state_reg   <= ST_DIV;
                                end
                            end
                            CMD_START: begin
                                elapsed_reg     <= '0;
                                oscillating_reg <= 1'b1;
                            end
                            CMD_SET: begin
                                oscillating_reg    <= 1'b0;
                                angle_now_reg      <= sp_angle;
                                m_position_reg     <= sp_angle;
                                m_drive_strobe_reg <= attached_reg;
                            end
                            CMD_STOP: begin
                                oscillating_reg <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_SINE;
                    end
                end
                ST_SINE: begin
                    if (sine_done) begin
                        state_reg <= ST_POST;
                    end
                end
                ST_POST: begin
                    // output register was emptied when the refresh was accepted
                    angle_now_reg      <= osc_angle;
                    m_valid_reg        <= 1'b1;
                    m_position_reg     <= osc_angle;
                    m_drive_strobe_reg <= 1'b1;
                    state_reg          <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_position     = m_position_reg;
    assign m_drive_strobe = m_drive_strobe_reg;

`ifndef ASSERT_OFF
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        angle_now_reg <= ANGLE_MAX[ANGLE_W-1:0])
        else $error("angle outside 0..180");

    a_post_drives: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POST) |=> (m_valid_reg && m_drive_strobe_reg))
        else $error("oscillation update did not produce a driving result");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_sine_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sine_done |-> (state_reg == ST_SINE))
        else $error("sine unit finished outside the sine phase");

    a_strobe_attached: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_drive_strobe_reg) |-> attached_reg)
        else $error("servo driven while detached");
`endif

endmodule
